### sv/ema_pkg.sv
// Shared constants and helpers for the echo moving-average filter.
package ema_pkg;

    // Window length and saturation limit of the conditioned echo width
    localparam int unsigned WINDOW_LEN  = 50;
    localparam int unsigned MAX_ECHO_US = 24000;

    // Field widths
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MEAN_W   = 16;

    // Running total never exceeds WINDOW_LEN * MAX_ECHO_US
    localparam longint unsigned TOTAL_MAX = longint'(WINDOW_LEN) * longint'(MAX_ECHO_US);
    localparam int unsigned     TOTAL_W   = $clog2(TOTAL_MAX + 1);

    // Reciprocal for total / WINDOW_LEN: quotient estimate is exact or one low
    localparam int unsigned     RECIP_SHIFT = TOTAL_W + 8;
    localparam longint unsigned RECIP       = (64'd1 << RECIP_SHIFT) / WINDOW_LEN;
    localparam int unsigned     RECIP_W     = $clog2(RECIP + 1);
    localparam int unsigned     PROD_W      = TOTAL_W + RECIP_W;

    // Timeout (zero) and over-range widths both become the maximum
    function automatic logic [SAMPLE_W-1:0] condition_sample(input logic [SAMPLE_W-1:0] raw);
        logic [SAMPLE_W-1:0] res;
        res = raw;
        if ((raw == '0) || (raw > (SAMPLE_W)'(MAX_ECHO_US))) begin
            res = (SAMPLE_W)'(MAX_ECHO_US);
        end
        return res;
    endfunction

endpackage

### sv/ema_cell.sv
// One window cell: holds a sample and passes it to the next cell on each item.
module ema_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  logic [ema_pkg::SAMPLE_W-1:0]  sample_in,
    output logic [ema_pkg::SAMPLE_W-1:0]  sample_out
);

    logic [ema_pkg::SAMPLE_W-1:0] sample_reg;

    // Window starts full of maximum-width samples
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= (ema_pkg::SAMPLE_W)'(ema_pkg::MAX_ECHO_US);
        end else if (shift_en) begin
            sample_reg <= sample_in;
        end
    end

    assign sample_out = sample_reg;

endmodule

### sv/ema_div.sv
// Two-stage divide of the running total by the window length, with handshake.
module ema_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ema_pkg::TOTAL_W-1:0]  in_total,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ema_pkg::MEAN_W-1:0]   out_mean
);

    logic                         prod_valid_reg;
    logic [ema_pkg::PROD_W-1:0]   prod_reg;
    logic [ema_pkg::TOTAL_W-1:0]  prod_total_reg;
    logic                         mean_valid_reg;
    logic [ema_pkg::MEAN_W-1:0]   mean_reg;

    logic                         prod_ready;
    logic                         mean_ready;
    logic [ema_pkg::PROD_W-1:0]   prod_next;
    logic [ema_pkg::MEAN_W-1:0]   q_est;
    logic [ema_pkg::TOTAL_W-1:0]  q_times_n;
    logic [ema_pkg::TOTAL_W-1:0]  rem;
    logic [ema_pkg::MEAN_W-1:0]   mean_next;

    // Stage readiness: a stage takes data when empty or draining
    assign mean_ready = !mean_valid_reg || out_ready;
    assign prod_ready = !prod_valid_reg || mean_ready;
    assign in_ready   = prod_ready;

    // Multiply by the scaled reciprocal
    assign prod_next = (ema_pkg::PROD_W)'(in_total)
                     * (ema_pkg::PROD_W)'(ema_pkg::RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
        end else if (prod_ready) begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && in_valid) begin
            prod_reg       <= prod_next;
            prod_total_reg <= in_total;
        end
    end

    // Quotient estimate is at most one low: fix with one remainder compare
    always_comb begin
        q_est     = (ema_pkg::MEAN_W)'(prod_reg >> ema_pkg::RECIP_SHIFT);
        q_times_n = (ema_pkg::TOTAL_W)'(q_est) * (ema_pkg::TOTAL_W)'(ema_pkg::WINDOW_LEN);
        rem       = prod_total_reg - q_times_n;
        mean_next = q_est;
        if (rem >= (ema_pkg::TOTAL_W)'(ema_pkg::WINDOW_LEN)) begin
            mean_next = q_est + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_valid_reg <= 1'b0;
        end else if (mean_ready) begin
            mean_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mean_ready && prod_valid_reg) begin
            mean_reg <= mean_next;
        end
    end

    assign out_valid = mean_valid_reg;
    assign out_mean  = mean_reg;

endmodule

### sv/echo_moving_average.sv
// Top level of the echo moving-average filter.
// Takes one echo width per item and returns the truncated mean of the last
// 50 conditioned widths (a zero or anything above 24000 counts as 24000).
// One item is accepted every cycle while results are taken. Each result
// passes through three register stages: the accepting edge shifts the
// sample into the chain of window cells and registers the updated running
// total, then the reciprocal multiply and the remainder correction register
// the division of the total by the window length. With the output held off,
// three items sit in the pipeline before the input stalls. After reset the
// window is full of 24000s.
module echo_moving_average (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ema_pkg::SAMPLE_W-1:0]  s_echo_width_us,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ema_pkg::MEAN_W-1:0]    m_mean_echo_us
);

    logic [ema_pkg::SAMPLE_W-1:0] cell_q [ema_pkg::WINDOW_LEN];
    logic [ema_pkg::SAMPLE_W-1:0] sample;
    logic                         accept;
    logic                         total_valid_reg;
    logic [ema_pkg::TOTAL_W-1:0]  total_reg;
    logic [ema_pkg::TOTAL_W-1:0]  total_next;
    logic                         div_ready;

    assign sample  = ema_pkg::condition_sample(s_echo_width_us);
    assign s_ready = !total_valid_reg || div_ready;
    assign accept  = s_valid && s_ready;

    // Window as a chain of cells; the last cell holds the oldest sample
    for (genvar i = 0; i < ema_pkg::WINDOW_LEN; i++) begin : g_cell
        if (i == 0) begin : g_head
            ema_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (accept),
                .sample_in  (sample),
                .sample_out (cell_q[i])
            );
        end else begin : g_body
            ema_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .shift_en   (accept),
                .sample_in  (cell_q[i-1]),
                .sample_out (cell_q[i])
            );
        end
    end

    // Running total: drop the oldest sample, add the new one
    assign total_next = total_reg
                      - (ema_pkg::TOTAL_W)'(cell_q[ema_pkg::WINDOW_LEN-1])
                      + (ema_pkg::TOTAL_W)'(sample);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg       <= (ema_pkg::TOTAL_W)'(ema_pkg::TOTAL_MAX);
            total_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                total_valid_reg <= s_valid;
            end
            if (accept) begin
                total_reg <= total_next;
            end
        end
    end

    // Divide by the window length
    ema_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (total_valid_reg),
        .in_ready  (div_ready),
        .in_total  (total_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_mean  (m_mean_echo_us)
    );

endmodule

### sv/ema_checker.sv
// Port-level checks for the echo moving-average filter, bound to the top level.
module ema_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [ema_pkg::SAMPLE_W-1:0]  s_echo_width_us,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [ema_pkg::MEAN_W-1:0]    m_mean_echo_us
);

    // Mean of conditioned samples lies between one and the maximum
    a_mean_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_mean_echo_us != '0)
                 && (m_mean_echo_us <= (ema_pkg::MEAN_W)'(ema_pkg::MAX_ECHO_US)))
        else $error("mean out of range");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

    // Empty output or a taking sink means the input side is open
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled without output back-pressure");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_mean_echo_us)))
        else $error("stalled result changed");

endmodule

bind echo_moving_average ema_checker u_ema_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_echo_width_us (s_echo_width_us),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_mean_echo_us  (m_mean_echo_us)
);

### tb/echo_moving_average_test.sv
// Self-checking testbench for the echo moving-average filter.
`timescale 1ns / 100ps

module echo_moving_average_test;

    localparam int unsigned WINDOW_LEN  = ema_pkg::WINDOW_LEN;
    localparam int unsigned MAX_ECHO_US = ema_pkg::MAX_ECHO_US;
    localparam int unsigned SAMPLE_W    = ema_pkg::SAMPLE_W;
    localparam int unsigned MEAN_W      = ema_pkg::MEAN_W;
    localparam int unsigned TOTAL_W     = ema_pkg::TOTAL_W;

    localparam int unsigned SLOT_W       = $clog2(WINDOW_LEN);
    localparam int unsigned TOTAL_WIDTHS = 600;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    // One directed row: echo width, and the mean when it is obvious by eye
    typedef struct packed {
        logic [SAMPLE_W-1:0] width;
        logic                fixed;
        logic [MEAN_W-1:0]   mean;
    } echo_row_t;

    typedef enum int {
        SEG_CONSTANT_RUN,
        SEG_IN_RANGE,
        SEG_FULL_RANGE,
        SEG_BOUNDARY
    } segment_t;

    localparam int unsigned DIRECTED_ROWS = 21;

    // Window is all MAX after reset, so the first few means stay at MAX
    localparam echo_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'd0,                      1'b1, MEAN_W'(MAX_ECHO_US)},  // timeout
        '{16'hFFFF,                   1'b1, MEAN_W'(MAX_ECHO_US)},  // top of range
        '{SAMPLE_W'(MAX_ECHO_US + 1), 1'b1, MEAN_W'(MAX_ECHO_US)},  // just over
        '{SAMPLE_W'(MAX_ECHO_US),     1'b1, MEAN_W'(MAX_ECHO_US)},  // exactly max
        '{16'h8000,                   1'b1, MEAN_W'(MAX_ECHO_US)},  // msb only
        '{16'd1,                      1'b0, '0},
        '{SAMPLE_W'(MAX_ECHO_US - 1), 1'b0, '0},
        '{16'd2,                      1'b0, '0},
        '{16'h5555,                   1'b0, '0},
        '{16'h2AAA,                   1'b0, '0},
        '{16'h00FF,                   1'b0, '0},
        '{16'h0F0F,                   1'b0, '0},
        '{16'h1234,                   1'b0, '0},
        '{16'd12000,                  1'b0, '0},
        '{16'd0,                      1'b0, '0},   // timeout mid-window
        '{16'hFFFF,                   1'b0, '0},
        '{16'h5DBF,                   1'b0, '0},
        '{16'h0001,                   1'b0, '0},
        '{16'h0100,                   1'b0, '0},
        '{16'h4000,                   1'b0, '0},
        '{16'h3C00,                   1'b0, '0}
    };

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [SAMPLE_W-1:0] s_echo_width_us = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [MEAN_W-1:0]   m_mean_echo_us;

    // Shadow of the filter window
    logic [SAMPLE_W-1:0] window_ring [WINDOW_LEN];
    logic [SLOT_W-1:0]   ring_slot;
    logic [TOTAL_W-1:0]  running_sum;

    logic [MEAN_W-1:0]   mean_queue [$];

    int unsigned widths_sent    = 0;
    int unsigned timeouts_sent  = 0;
    int unsigned overrange_sent = 0;
    int unsigned means_checked  = 0;
    int unsigned mismatches     = 0;
    int unsigned long_holds     = 0;
    logic [MEAN_W-1:0] lowest_mean  = '1;
    logic [MEAN_W-1:0] highest_mean = '0;

    // Pacing flags: rush paces the sender, calm and hold_pending also steer the receiver
    bit rush         = 1'b0;
    bit calm         = 1'b0;
    bit hold_pending = 1'b0;

    echo_moving_average uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_echo_width_us (s_echo_width_us),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_mean_echo_us  (m_mean_echo_us)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Mostly short idles, now and then a long one
    function automatic int unsigned pick_idle();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < WINDOW_LEN; i++) window_ring[i] = SAMPLE_W'(MAX_ECHO_US);
        ring_slot   = '0;
        running_sum = TOTAL_W'(WINDOW_LEN * MAX_ECHO_US);
    endfunction

    // Push one width into the shadow window and return the new mean
    function automatic logic [MEAN_W-1:0] window_mean(input logic [SAMPLE_W-1:0] width);
        logic [SAMPLE_W-1:0] clipped;
        clipped = (width != '0 && width <= SAMPLE_W'(MAX_ECHO_US)) ?
                  width : SAMPLE_W'(MAX_ECHO_US);
        running_sum = running_sum - TOTAL_W'(window_ring[ring_slot]) + TOTAL_W'(clipped);
        window_ring[ring_slot] = clipped;
        ring_slot = (ring_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : ring_slot + 1'b1;
        return MEAN_W'(running_sum / WINDOW_LEN);
    endfunction

    // Offer one width, wait for it to be taken, then record the expected mean
    task automatic offer_width(input logic [SAMPLE_W-1:0] width, input logic fixed,
                               input logic [MEAN_W-1:0] fixed_mean);
        int unsigned gap;
        logic [MEAN_W-1:0] predicted;
        gap = rush ? 0 : pick_idle();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_echo_width_us <= width;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = window_mean(width);
        mean_queue.push_back(fixed ? fixed_mean : predicted);
        widths_sent++;
        if (width == '0) timeouts_sent++;
        if (width > SAMPLE_W'(MAX_ECHO_US)) overrange_sent++;
    endtask

    // Result side: runs of ready with stalls in between, plus requested long holds
    initial begin : receiver
        int unsigned run_len;
        int unsigned stall;
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
                                                    $urandom_range(1, 8);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                long_holds++;
                stall = HOLD_CYCLES;
            end else if (calm) begin
                stall = 0;
            end else begin
                stall = pick_idle();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Compare every mean taken against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (mean_queue.size() == 0) begin
                $display("%0t: unexpected mean, expected none, got %0d",
                         $time, m_mean_echo_us);
                mismatches++;
            end else begin
                logic [MEAN_W-1:0] want;
                want = mean_queue.pop_front();
                means_checked++;
                if (m_mean_echo_us < lowest_mean)  lowest_mean  = m_mean_echo_us;
                if (m_mean_echo_us > highest_mean) highest_mean = m_mean_echo_us;
                if (m_mean_echo_us !== want) begin
                    $display("%0t: mean_echo_us mismatch, expected %0d, got %0d",
                             $time, want, m_mean_echo_us);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        segment_t            kind;
        int unsigned         roll;
        int unsigned         seg_len;
        int unsigned         next_hold_at;
        logic [SAMPLE_W-1:0] run_value;
        logic [SAMPLE_W-1:0] width;

        clear_window();
        next_hold_at = 150;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows
        foreach (directed_rows[i])
            offer_width(directed_rows[i].width, directed_rows[i].fixed, directed_rows[i].mean);

        // Random segments
        while (widths_sent < TOTAL_WIDTHS) begin
            roll = $urandom_range(0, 9);
            kind = (roll < 3) ? SEG_CONSTANT_RUN :
                   (roll < 6) ? SEG_IN_RANGE :
                   (roll < 8) ? SEG_FULL_RANGE : SEG_BOUNDARY;
            calm = ($urandom_range(0, 4) == 0);
            rush = calm;
            if (widths_sent >= next_hold_at) begin
                // keep offering while the output is held off, so the pipe backs up
                hold_pending = 1'b1;
                calm         = 1'b0;
                rush         = 1'b1;
                next_hold_at = next_hold_at + 250;
            end

            case (kind)
                SEG_CONSTANT_RUN: seg_len = $urandom_range(WINDOW_LEN, WINDOW_LEN + 20);
                SEG_IN_RANGE:     seg_len = $urandom_range(20, 60);
                SEG_FULL_RANGE:   seg_len = $urandom_range(10, 40);
                default:          seg_len = $urandom_range(10, 30);
            endcase

            case ($urandom_range(0, 4))
                0:       run_value = 16'd1;
                1:       run_value = SAMPLE_W'(MAX_ECHO_US);
                2:       run_value = 16'd0;
                3:       run_value = 16'hFFFF;
                default: run_value = SAMPLE_W'($urandom_range(1, MAX_ECHO_US));
            endcase

            for (int k = 0; k < seg_len; k++) begin
                case (kind)
                    SEG_CONSTANT_RUN: width = run_value;
                    SEG_IN_RANGE:     width = SAMPLE_W'($urandom_range(1, MAX_ECHO_US));
                    SEG_FULL_RANGE:   width = SAMPLE_W'($urandom_range(0, 65535));
                    default: begin
                        case ($urandom_range(0, 7))
                            0:       width = 16'd0;
                            1:       width = 16'd1;
                            2:       width = 16'd2;
                            3:       width = SAMPLE_W'(MAX_ECHO_US - 1);
                            4:       width = SAMPLE_W'(MAX_ECHO_US);
                            5:       width = SAMPLE_W'(MAX_ECHO_US + 1);
                            6:       width = 16'hFFFE;
                            default: width = 16'hFFFF;
                        endcase
                    end
                endcase
                offer_width(width, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        calm = 1'b0;
        rush = 1'b0;

        // Drain, then allow for any stray result
        while (mean_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("summary: %0d widths sent (%0d timeouts, %0d over range), %0d means checked",
                 widths_sent, timeouts_sent, overrange_sent, means_checked);
        $display("summary: %0d long output holds, means seen from %0d to %0d, %0d mismatches",
                 long_holds, lowest_mean, highest_mean, mismatches);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
